// ===== design/dia_pkg.sv =====
// Shared types and constants of the descriptor id allocator.
package dia_pkg;

	localparam int WORD_W    = 8;   // free-map bits per memory row
	localparam int WORD_IW   = 3;   // bit index inside a row
	localparam int RUN_W     = 7;   // run length field
	localparam int HS_W      = 11;  // heap_slots register
	localparam int INC_W     = 13;  // increment_size register
	localparam int ADDR_W    = 64;  // address registers and results
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SLOTS = 3'd4;

	localparam logic [INC_W-1:0] INC_RESET = 13'd32;
	localparam logic [HS_W-1:0]  HS_RESET  = 11'd1024;
	localparam logic             VIS_RESET = 1'b1;

	typedef struct packed {
		logic               hit;
		logic [WORD_IW-1:0] pos;
		logic [RUN_W-1:0]   run_out;
	} dia_scan_t;

endpackage

// ===== design/descriptor_id_allocator.sv =====
// Top level of the descriptor id allocator: sequencer, free map and address unit.
//
// Hands out heap slot ids 1..min(heap_slots, CAPACITY) from a free bitmap and
// a bump pointer, and turns ids into CPU/GPU addresses (base + (id-1) * stride).
// The free map lives in a RAM of CAPACITY/8+1 rows of 8 bits; after reset a
// clearing pass writes every row to zero, with in_ready low (configuration
// writes are taken as ever). One item is handled at a time and in_ready stays
// low while it is in work. A free reads the row of its id and writes it back
// with the bit set, and gives no result; an ignored id touches no row. A lookup,
// a bad run length and each result word pass the address unit (one multiply
// stage, one 64-bit add stage). Single and run allocations first walk the free
// map one row per cycle through the shared row scanner, on to the last row
// when nothing is free and stopping early on a hit; then each result word
// passes the address unit. A run of n ids gives n result words, the last
// one flagged by last. The output register holds a finished word until
// out_ready, and the sequencer holds the next word back until that register
// is free.
module descriptor_id_allocator #(
	parameter int CAPACITY = 1024,
	parameter int MAX_RUN  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [dia_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dia_pkg::ADDR_W-1:0]          cfg_wdata,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dia_pkg::KIND_W-1:0]          kind,
	input  logic [dia_pkg::RUN_W-1:0]           run_length,
	input  logic [$clog2(CAPACITY+1)-1:0]       slot_id,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dia_pkg::STATUS_W-1:0]        status,
	output logic [$clog2(CAPACITY+1)-1:0]       result_id,
	output logic [dia_pkg::ADDR_W-1:0]          cpu_address,
	output logic [dia_pkg::ADDR_W-1:0]          gpu_address,
	output logic                                last
);
	import dia_pkg::*;

	localparam int ID_W  = $clog2(CAPACITY + 1);
	localparam int NU_W  = $clog2(CAPACITY + 2);
	localparam int ROWS  = CAPACITY / WORD_W + 1;
	localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BI_W  = RA_W + WORD_IW;
	localparam int SW    = ((BI_W > RUN_W) ? BI_W : RUN_W) + 1;
	localparam int CMP_W = ((NU_W > HS_W) ? NU_W : HS_W) + 1;
	localparam int MUL_W = ID_W + INC_W;

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_FREE_RD = 3'd2;
	localparam logic [2:0] S_FREE_WR = 3'd3;
	localparam logic [2:0] S_SCAN0   = 3'd4;
	localparam logic [2:0] S_SCAN    = 3'd5;
	localparam logic [2:0] S_EM_A    = 3'd6;
	localparam logic [2:0] S_EM_B    = 3'd7;

	// configuration registers
	logic [ADDR_W-1:0] cpu_base_q;
	logic [ADDR_W-1:0] gpu_base_q;
	logic [INC_W-1:0]  increment_q;
	logic              visible_q;
	logic [HS_W-1:0]   heap_slots_q;

	// sequencer state
	logic [2:0]        state_q;
	logic [RA_W-1:0]   row_q;
	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  need_q;
	logic              single_q;
	logic [ID_W-1:0]   sid_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [RUN_W-1:0]  remain_q;
	logic [STATUS_W-1:0] res_status_q;
	logic              ok_q;
	logic              clr_q;
	logic [NU_W-1:0]   next_unused_q;
	logic [MUL_W-1:0]  off_s1;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     result_id_q;
	logic [ADDR_W-1:0]   cpu_address_q;
	logic [ADDR_W-1:0]   gpu_address_q;
	logic                last_q;

	// free-map RAM
	logic              ram_we;
	logic [RA_W-1:0]   ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [RA_W-1:0]   ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	dia_scan_t         scan;
	logic [CMP_W-1:0]  eff_slots;
	logic [CMP_W-1:0]  nu_ext;
	logic              bump1_ok;
	logic              bumpn_ok;
	logic              out_free;
	logic              last_row;
	logic              free_ok;
	logic              lookup_bad;
	logic              len_bad;
	logic [SW-1:0]     hit_start;
	logic [RA_W-1:0]   sid_row;
	logic [RA_W-1:0]   cur_row;
	logic [WORD_W-1:0] sid_mask;
	logic [WORD_W-1:0] cur_mask;

	dia_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dia_scan u_scan (
		.word   (ram_rdata),
		.run_in (run_q),
		.need   (need_q),
		.single (single_q),
		.res    (scan)
	);

	// Heap size seen by the bump pointer: heap_slots, capped at CAPACITY.
	always_comb begin
		if (CMP_W'(heap_slots_q) > CMP_W'(CAPACITY)) begin
			eff_slots = CMP_W'(CAPACITY);
		end else begin
			eff_slots = CMP_W'(heap_slots_q);
		end
	end

	assign nu_ext   = CMP_W'(next_unused_q);
	assign bump1_ok = nu_ext <= eff_slots;
	assign bumpn_ok = (nu_ext + CMP_W'(need_q) - CMP_W'(1)) <= eff_slots;
	assign out_free = !out_valid_q || out_ready;
	assign last_row = row_q == RA_W'(ROWS - 1);

	// Checks on an incoming request, taken straight from the ports.
	assign free_ok    = (slot_id != '0) && (slot_id <= ID_W'(CAPACITY))
	                    && (CMP_W'(slot_id) < nu_ext);
	assign lookup_bad = (slot_id == '0) || (CMP_W'(slot_id) >= nu_ext);
	assign len_bad    = (run_length == '0) || (run_length > RUN_W'(MAX_RUN));

	// First id of the hit: the bit itself for a single, run start otherwise.
	always_comb begin
		if (single_q) begin
			hit_start = SW'({row_q, scan.pos});
		end else begin
			hit_start = SW'({row_q, scan.pos}) - SW'(need_q) + SW'(1);
		end
	end

	assign sid_row  = RA_W'(sid_q >> WORD_IW);
	assign cur_row  = RA_W'(cur_id_q >> WORD_IW);
	assign sid_mask = WORD_W'(1) << WORD_IW'(sid_q);
	assign cur_mask = WORD_W'(1) << WORD_IW'(cur_id_q);

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = '0;
		ram_raddr = row_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_FREE_RD: begin
				ram_raddr = sid_row;
			end
			S_FREE_WR: begin
				// set the freed bit, keep the rest of the row
				ram_we    = 1'b1;
				ram_waddr = sid_row;
				ram_wdata = ram_rdata | sid_mask;
			end
			S_SCAN0: begin
				ram_raddr = '0;
			end
			S_SCAN: begin
				// fetch the next row while this one is scanned
				ram_raddr = last_row ? row_q : row_q + RA_W'(1);
			end
			S_EM_A: begin
				ram_raddr = cur_row;
			end
			S_EM_B: begin
				// take an id out of the free map when it came from there
				ram_we    = clr_q;
				ram_waddr = cur_row;
				ram_wdata = ram_rdata & ~cur_mask;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_base_q   <= '0;
			gpu_base_q   <= '0;
			increment_q  <= INC_RESET;
			visible_q    <= VIS_RESET;
			heap_slots_q <= HS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CPU_BASE:   cpu_base_q   <= cfg_wdata;
				REG_GPU_BASE:   gpu_base_q   <= cfg_wdata;
				REG_INCREMENT:  increment_q  <= cfg_wdata[INC_W-1:0];
				REG_VISIBLE:    visible_q    <= cfg_wdata[0];
				REG_HEAP_SLOTS: heap_slots_q <= cfg_wdata[HS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			row_q         <= '0;
			run_q         <= '0;
			need_q        <= '0;
			single_q      <= 1'b0;
			sid_q         <= '0;
			cur_id_q      <= '0;
			remain_q      <= '0;
			res_status_q  <= ST_OK;
			ok_q          <= 1'b0;
			clr_q         <= 1'b0;
			next_unused_q <= NU_W'(1);
		end else begin
			case (state_q)
				S_CLEAR: begin
					// sweep the free map to all clear, one row a cycle
					row_q <= row_q + RA_W'(1);
					if (last_row) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (kind)
							KIND_FREE: begin
								sid_q   <= slot_id;
								state_q <= free_ok ? S_FREE_RD : S_IDLE;
							end
							KIND_LOOKUP: begin
								cur_id_q     <= slot_id;
								remain_q     <= RUN_W'(1);
								clr_q        <= 1'b0;
								ok_q         <= !lookup_bad;
								res_status_q <= lookup_bad ? ST_RANGE : ST_OK;
								state_q      <= S_EM_A;
							end
							KIND_ALLOC: begin
								single_q <= 1'b1;
								need_q   <= RUN_W'(1);
								run_q    <= '0;
								state_q  <= S_SCAN0;
							end
							KIND_RUN: begin
								if (len_bad) begin
									cur_id_q     <= '0;
									remain_q     <= RUN_W'(1);
									clr_q        <= 1'b0;
									ok_q         <= 1'b0;
									res_status_q <= ST_RANGE;
									state_q      <= S_EM_A;
								end else begin
									single_q <= 1'b0;
									need_q   <= run_length;
									run_q    <= '0;
									state_q  <= S_SCAN0;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q <= S_IDLE;
				end
				S_SCAN0: begin
					row_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan.hit) begin
						cur_id_q     <= ID_W'(hit_start);
						remain_q     <= need_q;
						clr_q        <= 1'b1;
						ok_q         <= 1'b1;
						res_status_q <= ST_OK;
						state_q      <= S_EM_A;
					end else if (last_row) begin
						// nothing freed fits: fall back to the bump pointer
						clr_q   <= 1'b0;
						state_q <= S_EM_A;
						if (single_q ? bump1_ok : bumpn_ok) begin
							cur_id_q      <= ID_W'(next_unused_q);
							remain_q      <= need_q;
							ok_q          <= 1'b1;
							res_status_q  <= ST_OK;
							next_unused_q <= NU_W'(nu_ext + CMP_W'(need_q));
						end else begin
							cur_id_q     <= '0;
							remain_q     <= RUN_W'(1);
							ok_q         <= 1'b0;
							res_status_q <= ST_FULL;
						end
					end else begin
						row_q <= row_q + RA_W'(1);
						run_q <= scan.run_out;
					end
				end
				S_EM_A: begin
					if (out_free) begin
						state_q <= S_EM_B;
					end
				end
				S_EM_B: begin
					if (remain_q == RUN_W'(1)) begin
						state_q <= S_IDLE;
					end else begin
						cur_id_q <= cur_id_q + ID_W'(1);
						remain_q <= remain_q - RUN_W'(1);
						state_q  <= S_EM_A;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Address unit, stage one: slot offset (id - 1) * stride.
	always_ff @(posedge clk) begin
		if (state_q == S_EM_A && out_free) begin
			off_s1 <= MUL_W'(cur_id_q - ID_W'(1)) * MUL_W'(increment_q);
		end
	end

	// Output register: valid is control, the payload loads with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EM_B) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Address unit, stage two: add the bases; zero on failure, GPU side also when invisible.
	always_ff @(posedge clk) begin
		if (state_q == S_EM_B) begin
			status_q      <= res_status_q;
			result_id_q   <= ok_q ? cur_id_q : '0;
			cpu_address_q <= ok_q ? cpu_base_q + ADDR_W'(off_s1) : '0;
			gpu_address_q <= (ok_q && visible_q) ? gpu_base_q + ADDR_W'(off_s1) : '0;
			last_q        <= remain_q == RUN_W'(1);
		end
	end

	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_id   = result_id_q;
	assign cpu_address = cpu_address_q;
	assign gpu_address = gpu_address_q;
	assign last        = last_q;

endmodule

// ===== design/dia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dia_scan.sv =====
// Free-map row scanner: lowest set bit, or first point where a run reaches the wanted length.
module dia_scan (
	input  logic [dia_pkg::WORD_W-1:0] word,
	input  logic [dia_pkg::RUN_W-1:0]  run_in,
	input  logic [dia_pkg::RUN_W-1:0]  need,
	input  logic                       single,
	output dia_pkg::dia_scan_t         res
);
	import dia_pkg::*;

	always_comb begin : p_scan
		logic [RUN_W-1:0] r;
		logic             found;
		r     = run_in;
		found = 1'b0;
		res   = '0;
		for (int j = 0; j < WORD_W; j++) begin
			// extend the run through set bits, restart on a clear bit
			r = word[j] ? r + RUN_W'(1) : '0;
			if (!found && ((single && word[j]) || (!single && r == need))) begin
				found   = 1'b1;
				res.hit = 1'b1;
				res.pos = WORD_IW'(j);
			end
		end
		res.run_out = r;
	end

endmodule

// ===== design/dia_chk.sv =====
// Port-level checker for the descriptor id allocator, bound to the top level.
module dia_chk #(
	parameter int ID_W = 11
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [dia_pkg::KIND_W-1:0]    kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [dia_pkg::STATUS_W-1:0]  status,
	input logic [ID_W-1:0]               result_id,
	input logic [dia_pkg::ADDR_W-1:0]    cpu_address,
	input logic [dia_pkg::ADDR_W-1:0]    gpu_address,
	input logic                          last
);
	import dia_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_id)
		&& $stable(cpu_address) && $stable(gpu_address) && $stable(last))
		else $error("result word changed while stalled");

	// a failed request ends its item with an empty word
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && result_id == '0
		&& cpu_address == '0 && gpu_address == '0)
		else $error("failure word carries an id or address");

	// a good word always names a real slot
	a_ok_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> result_id != '0)
		else $error("good word with id zero");

	// any request other than a free keeps the block busy for a while
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_FREE |=> !in_ready)
		else $error("request taken while the previous one is in work");

endmodule

bind descriptor_id_allocator dia_chk #(
	.ID_W (ID_W)
) u_dia_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.result_id   (result_id),
	.cpu_address (cpu_address),
	.gpu_address (gpu_address),
	.last        (last)
);

// ===== tb/descriptor_id_allocator_tb.sv =====
// Self-checking testbench of the descriptor id allocator, with a predicting scoreboard.
module descriptor_id_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dia_pkg::*;

	localparam int CAPACITY    = 1024;
	localparam int MAX_RUN     = 64;
	localparam int ID_W        = $clog2(CAPACITY + 1);
	// Longest quiet stretch is the clearing pass or a full free-map walk
	// plus the longest drawn request gap and output stall.
	localparam int STALL_LIMIT = 1500;
	localparam int PHASE_ITEMS = 46;
	localparam int PRINT_CAP   = 30;

	// One result word as the block should present it.
	typedef struct {
		logic [STATUS_W-1:0] stat;
		logic [ID_W-1:0]     id;
		logic [ADDR_W-1:0]   cpu;
		logic [ADDR_W-1:0]   gpu;
		logic                fin;
	} slot_word_t;

	// Tracks the freed-id bitmap, the bump pointer and the registers, and keeps
	// the words each accepted request is due to produce, oldest first.
	class slot_scoreboard;
		bit                freed [0:CAPACITY];
		int unsigned       bump_id;
		logic [ADDR_W-1:0] cpu_base;
		logic [ADDR_W-1:0] gpu_base;
		logic [INC_W-1:0]  stride;
		logic              visible;
		logic [HS_W-1:0]   heap_slots;
		slot_word_t        due_words [$];
		int unsigned       mismatches;
		int unsigned       words_seen;
		int unsigned       full_seen;
		int unsigned       range_seen;
		int unsigned       kind_seen [4];

		function new();
			foreach (freed[i]) freed[i] = 1'b0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			bump_id    = 1;
			cpu_base   = '0;
			gpu_base   = '0;
			stride     = INC_RESET;
			visible    = VIS_RESET;
			heap_slots = HS_RESET;
			mismatches = 0;
			words_seen = 0;
			full_seen  = 0;
			range_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
			case (idx)
			REG_CPU_BASE:   cpu_base   = value;
			REG_GPU_BASE:   gpu_base   = value;
			REG_INCREMENT:  stride     = value[INC_W-1:0];
			REG_VISIBLE:    visible    = value[0];
			REG_HEAP_SLOTS: heap_slots = value[HS_W-1:0];
			default: ;
			endcase
		endfunction

		function void push_word(logic [STATUS_W-1:0] code, int unsigned id, bit fin);
			slot_word_t        w;
			logic [ADDR_W-1:0] offset;
			bit                granted;
			granted = (code == ST_OK);
			// address math wraps at 64 bits
			offset  = (ADDR_W'(id) - 64'd1) * ADDR_W'(stride);
			w.stat  = code;
			w.id    = granted ? ID_W'(id) : '0;
			w.cpu   = granted ? cpu_base + offset : '0;
			w.gpu   = (granted && visible) ? gpu_base + offset : '0;
			w.fin   = fin;
			due_words = {due_words, w};
		endfunction

		function void note_request(logic [KIND_W-1:0] op, logic [RUN_W-1:0] len,
				logic [ID_W-1:0] sid);
			int unsigned id_limit;
			int unsigned streak;
			int unsigned start;
			int unsigned n;
			int unsigned i;
			id_limit = (heap_slots > CAPACITY) ? CAPACITY : heap_slots;
			n        = len;
			kind_seen[op]++;
			case (op)
			KIND_ALLOC: begin
				for (i = 1; i <= CAPACITY; i++) begin
					if (freed[i]) begin
						freed[i] = 1'b0;
						push_word(ST_OK, i, 1'b1);
						return;
					end
				end
				if (bump_id <= id_limit) begin
					push_word(ST_OK, bump_id, 1'b1);
					bump_id++;
				end else begin
					push_word(ST_FULL, 0, 1'b1);
				end
			end
			KIND_RUN: begin
				if (n == 0 || n > MAX_RUN) begin
					push_word(ST_RANGE, 0, 1'b1);
					return;
				end
				streak = 0;
				start  = 0;
				for (i = 1; i <= CAPACITY && start == 0; i++) begin
					streak = freed[i] ? streak + 1 : 0;
					if (streak == n) start = i - n + 1;
				end
				if (start == 0) begin
					if (bump_id + n - 1 > id_limit) begin
						push_word(ST_FULL, 0, 1'b1);
						return;
					end
					start    = bump_id;
					bump_id += n;
				end else begin
					for (i = start; i < start + n; i++) freed[i] = 1'b0;
				end
				for (i = 0; i < n; i++) push_word(ST_OK, start + i, i + 1 == n);
			end
			KIND_FREE: begin
				// ids never handed out, id 0 and ids past the capacity are dropped
				if (sid != 0 && sid <= CAPACITY && sid < bump_id) freed[sid] = 1'b1;
			end
			KIND_LOOKUP: begin
				if (sid == 0 || sid >= bump_id) push_word(ST_RANGE, 0, 1'b1);
				else push_word(ST_OK, sid, 1'b1);
			end
			default: ;
			endcase
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_word(logic [STATUS_W-1:0] stat, logic [ID_W-1:0] id,
				logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu, logic fin);
			slot_word_t want;
			words_seen++;
			if (due_words.size() == 0) begin
				report($sformatf("word with nothing pending: status %0d id %0d", stat, id));
				return;
			end
			want        = due_words.pop_front();
			full_seen  += (want.stat == ST_FULL);
			range_seen += (want.stat == ST_RANGE);
			if (stat !== want.stat)
				report($sformatf("status %0d, want %0d (id %0d)", stat, want.stat, want.id));
			if (id !== want.id)
				report($sformatf("result_id %0d, want %0d", id, want.id));
			if (cpu !== want.cpu)
				report($sformatf("cpu_address %h, want %h (id %0d)", cpu, want.cpu, want.id));
			if (gpu !== want.gpu)
				report($sformatf("gpu_address %h, want %h (id %0d)", gpu, want.gpu, want.id));
			if (fin !== want.fin)
				report($sformatf("last %b, want %b (id %0d)", fin, want.fin, want.id));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [ADDR_W-1:0]     cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind;
	logic [RUN_W-1:0]      run_length;
	logic [ID_W-1:0]       slot_id;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [ID_W-1:0]       result_id;
	logic [ADDR_W-1:0]     cpu_address;
	logic [ADDR_W-1:0]     gpu_address;
	logic                  last;

	bit                    no_idle;
	int unsigned           items_sent;
	int unsigned           phases_run;
	slot_scoreboard        sb;

	descriptor_id_allocator #(
		.CAPACITY(CAPACITY),
		.MAX_RUN (MAX_RUN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.run_length (run_length),
		.slot_id    (slot_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.result_id  (result_id),
		.cpu_address(cpu_address),
		.gpu_address(gpu_address),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Present one request word and hold it until taken, then note it in the
	// scoreboard. Draw the gap after it: on a zero gap keep valid high so the
	// next call swaps the payload on the same edge.
	task automatic send_request(logic [KIND_W-1:0] op, logic [RUN_W-1:0] len,
			logic [ID_W-1:0] sid);
		int unsigned gap;
		in_valid   <= 1'b1;
		kind       <= op;
		run_length <= len;
		slot_id    <= sid;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_request(op, len, sid);
		items_sent++;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every pending word, then give a free that gives no
	// word time to finish inside the block.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Write all five registers back to back while the block is idle.
	task automatic apply_settings(input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
			input logic [INC_W-1:0] inc, input logic vis, input logic [HS_W-1:0] slots);
		logic [ADDR_W-1:0] junk;
		junk = {$urandom(), $urandom()};
		settle();
		put_reg(REG_CPU_BASE, cpu);
		put_reg(REG_GPU_BASE, gpu);
		// narrow registers keep only their low bits; fill the rest with noise
		put_reg(REG_INCREMENT, {junk[ADDR_W-1:INC_W], inc});
		put_reg(REG_VISIBLE, {junk[ADDR_W-1:1], vis});
		put_reg(REG_HEAP_SLOTS, {junk[ADDR_W-1:HS_W], slots});
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	// An id that has been handed out at some point.
	function automatic logic [ID_W-1:0] issued_id();
		return (sb.bump_id > 1) ? ID_W'($urandom_range(1, sb.bump_id - 1)) : '0;
	endfunction

	// Id 0, or an id never handed out, possibly past the capacity.
	function automatic logic [ID_W-1:0] stray_id();
		return ($urandom_range(0, 3) == 0) ? '0 : ID_W'($urandom_range(sb.bump_id, 2047));
	endfunction

	task automatic issue_random();
		int unsigned      pick;
		int unsigned      span;
		int unsigned      first;
		int unsigned      j;
		logic [RUN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 10 && sb.bump_id > 9) begin
			// free a contiguous block, then claim a run that fits in it
			span  = $urandom_range(2, 8);
			first = $urandom_range(1, sb.bump_id - span);
			for (j = 0; j < span; j++)
				send_request(KIND_FREE, RUN_W'($urandom), ID_W'(first + j));
			send_request(KIND_RUN, RUN_W'($urandom_range(1, span)), ID_W'($urandom));
		end else if (pick < 33) begin
			send_request(KIND_ALLOC, RUN_W'($urandom), ID_W'($urandom));
		end else if (pick < 53) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = ($urandom_range(0, 1) != 0) ? '0 : RUN_W'($urandom_range(MAX_RUN + 1, 127));
			else if (pick < 3)
				len = RUN_W'($urandom_range(9, MAX_RUN));
			else
				len = RUN_W'($urandom_range(1, 8));
			send_request(KIND_RUN, len, ID_W'($urandom));
		end else if (pick < 80) begin
			send_request(KIND_FREE, RUN_W'($urandom),
				($urandom_range(0, 6) == 0) ? stray_id() : issued_id());
		end else begin
			send_request(KIND_LOOKUP, RUN_W'($urandom),
				($urandom_range(0, 4) == 0) ? stray_id() : issued_id());
		end
	endtask

	// Drop ready for a drawn number of cycles before each word, then hold it
	// high until a word is taken.
	initial begin : result_sink
		int unsigned hold;
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 10);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
		end
	end

	// Check every word taken on the result channel against the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_word(status, result_id, cpu_address, gpu_address, last);
	end

	// Abort when neither channel nor the register port moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned target;
		int unsigned k;
		sb         = new();
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		kind       = KIND_ALLOC;
		run_length = '0;
		slot_id    = '0;
		out_ready  = 1'b0;
		no_idle    = 1'b0;
		items_sent = 0;
		phases_run = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values. The block is still
		// clearing its free map, so the first word waits for ready.
		send_request(KIND_LOOKUP, RUN_W'($urandom), '0);         // id 0 never maps
		send_request(KIND_LOOKUP, RUN_W'($urandom), ID_W'(1));   // nothing handed out yet
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(1));     // never handed out: dropped
		send_request(KIND_ALLOC, RUN_W'($urandom), ID_W'($urandom));
		send_request(KIND_RUN, '0, ID_W'($urandom));             // zero length
		send_request(KIND_RUN, RUN_W'(MAX_RUN + 1), ID_W'($urandom));
		send_request(KIND_RUN, RUN_W'(MAX_RUN), ID_W'($urandom)); // longest run, all bump ids
		send_request(KIND_RUN, RUN_W'(1), ID_W'($urandom));
		send_request(KIND_FREE, RUN_W'($urandom), '0);
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(2047));  // past the capacity
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(10));
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(11));
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(12));
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(20));
		send_request(KIND_RUN, RUN_W'(3), ID_W'($urandom));      // reuses the freed block
		send_request(KIND_ALLOC, RUN_W'($urandom), ID_W'($urandom)); // lowest freed id
		send_request(KIND_LOOKUP, RUN_W'($urandom), ID_W'(66));
		send_request(KIND_LOOKUP, RUN_W'($urandom), ID_W'(67));  // at the bump pointer
		send_request(KIND_LOOKUP, RUN_W'($urandom), ID_W'(CAPACITY));

		// Top addresses wrap, GPU side hidden, heap just past the bump pointer:
		// exhaust it, then satisfy a run only from freed ids.
		apply_settings('1, 64'h8000_0000_0000_0000, 13'd4096, 1'b0, 11'd68);
		for (k = 0; k < 3; k++)
			send_request(KIND_ALLOC, RUN_W'($urandom), ID_W'($urandom));
		send_request(KIND_RUN, RUN_W'(2), ID_W'($urandom));      // does not fit
		send_request(KIND_LOOKUP, RUN_W'($urandom), ID_W'(68));
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(30));
		send_request(KIND_FREE, RUN_W'($urandom), ID_W'(31));
		send_request(KIND_RUN, RUN_W'(3), ID_W'($urandom));      // freed block too short
		send_request(KIND_RUN, RUN_W'(2), ID_W'($urandom));

		// Random phases, each under its own register setting.
		for (k = 0; k < 5; k++) begin
			case (k)
			0: apply_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
					13'd1, 1'b1, HS_RESET);
			1: apply_settings('0, '1, '1, 1'b1, '1);
			2: apply_settings('1, {$urandom(), $urandom()}, '0, 1'b0,
					HS_W'((sb.bump_id + 20 > CAPACITY) ? CAPACITY : sb.bump_id + 20));
			3: apply_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
					INC_W'($urandom_range(1, 4096)), 1'b1, 11'd1);
			default: apply_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
					13'd4096, 1'b1, HS_RESET);
			endcase
			// run one phase back to back on both sides
			no_idle = (k == 1);
			target  = items_sent + PHASE_ITEMS;
			while (items_sent < target) issue_random();
		end

		settle();
		$display("Sent %0d requests (%0d single, %0d run, %0d free, %0d lookup) under %0d settings.",
			items_sent, sb.kind_seen[KIND_ALLOC], sb.kind_seen[KIND_RUN],
			sb.kind_seen[KIND_FREE], sb.kind_seen[KIND_LOOKUP], phases_run + 1);
		$display("Checked %0d result words: %0d heap full, %0d out of range, %0d mismatches.",
			sb.words_seen, sb.full_seen, sb.range_seen, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
